/* design/cpin_pkg.sv */
// Shared constants, widths and types for the contour inside and near test.
// Used by cpin_scan and contour_point_inside_and_near_test_unit.
// No dependencies.
package cpin_pkg;

    // Vertex store depth and the widths that follow from it.
    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    // Fixed field widths.
    localparam int MIN_LEN_W = 11;
    localparam int LEN_W = (CNT_W > MIN_LEN_W) ? CNT_W : MIN_LEN_W;
    localparam int COORD_W = 16;
    localparam int VERT_W = 2 * COORD_W;
    localparam int QUERY_W = 14;
    localparam int DIST_W = 13;
    localparam int SCOORD_W = QUERY_W + 1;
    localparam int SDIST_W = DIST_W + 1;
    localparam int CALC_W = 18;

    // Exclusion radius around inner vertices for inside queries.
    localparam logic [SDIST_W-1:0] NEAR_LIMIT = SDIST_W'(4);

    // Bounding box values of an empty contour.
    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

    // Request action codes.
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_INSIDE = 2'd1;
    localparam logic [1:0] ACT_NEAR = 2'd2;

    // Pass kinds run by the scan unit.
    typedef enum logic [1:0] {
        SCAN_RIGHT,
        SCAN_LEFT,
        SCAN_PROX
    } scan_mode_t;

    // Command from the sequencer to the scan unit.
    typedef struct packed {
        logic                start;
        scan_mode_t          mode;
        logic [SCOORD_W-1:0] sx;
        logic [SCOORD_W-1:0] sy;
        logic [SDIST_W-1:0]  radius;
        logic [CNT_W-1:0]    count;
    } scan_cmd_t;

    // Status from the scan unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } scan_stat_t;

endpackage

/* design/cpin_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// Holds the contour vertices; no dependencies.
module cpin_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/cpin_scan.sv */
// Scan unit: streams the stored vertices one per cycle and runs one pass of
// ray crossing parity or proximity search. Depends on cpin_pkg and on a
// vertex RAM with a registered read.
module cpin_scan (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cpin_pkg::scan_cmd_t       cmd,
    output logic                      rd_en,
    output logic [cpin_pkg::ADDR_W-1:0] rd_addr,
    input  logic [cpin_pkg::VERT_W-1:0] rd_data,
    output cpin_pkg::scan_stat_t      stat
);
    import cpin_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } scan_state_t;

    scan_state_t                state_reg, state_next;
    logic [CNT_W-1:0]           issue_reg, issue_next;
    logic                       dvalid_reg, dvalid_next;
    logic [CNT_W-1:0]           didx_reg, didx_next;
    logic                       run_reg, run_next;
    logic signed [COORD_W-1:0]  run_prev_reg, run_prev_next;
    logic signed [COORD_W-1:0]  prev_y_reg, prev_y_next;
    logic                       hit_reg, hit_next;

    logic signed [COORD_W-1:0]  vert_x, vert_y;
    logic signed [CALC_W-1:0]   sx_ext, sy_ext, dx, dy, adx, ady;
    logic                       inner, y_on_row, x_side, in_reach, done;

    // Vertex fields and the shared compare datapath.
    always_comb
    begin
        vert_x = rd_data[VERT_W-1:COORD_W];
        vert_y = rd_data[COORD_W-1:0];
        sx_ext = $signed(CALC_W'(cmd.sx));
        sy_ext = $signed(CALC_W'(cmd.sy));
        dx = CALC_W'(vert_x) - sx_ext;
        dy = CALC_W'(vert_y) - sy_ext;
        adx = dx[CALC_W-1] ? -dx : dx;
        ady = dy[CALC_W-1] ? -dy : dy;
        in_reach = (adx[CALC_W-2:0] <= (CALC_W-1)'(cmd.radius)) &&
                   (ady[CALC_W-2:0] <= (CALC_W-1)'(cmd.radius));
        y_on_row = (CALC_W'(vert_y) == sy_ext);
        x_side = (cmd.mode == SCAN_LEFT) ? (CALC_W'(vert_x) < sx_ext)
                                         : (CALC_W'(vert_x) > sx_ext);
        // Only vertices other than the first and the last take part.
        inner = (didx_reg != '0) && (CNT_W'(didx_reg + 1'b1) < cmd.count);
    end

    // Read issue and end of pass.
    always_comb
    begin
        rd_en = (state_reg == S_RUN) && (issue_reg < cmd.count);
        rd_addr = issue_reg[ADDR_W-1:0];
        done = (state_reg == S_RUN) && !rd_en && !dvalid_reg;
    end

    // Sequencing and per-vertex update.
    always_comb
    begin
        state_next = state_reg;
        issue_next = issue_reg;
        dvalid_next = 1'b0;
        didx_next = issue_reg;
        run_next = run_reg;
        run_prev_next = run_prev_reg;
        prev_y_next = prev_y_reg;
        hit_next = hit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    issue_next = '0;
                    run_next = 1'b0;
                    hit_next = 1'b0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (rd_en)
                begin
                    issue_next = CNT_W'(issue_reg + 1'b1);
                end
                dvalid_next = rd_en;
                if (dvalid_reg)
                begin
                    prev_y_next = vert_y;
                    if (inner)
                    begin
                        unique case (cmd.mode)
                            SCAN_RIGHT, SCAN_LEFT:
                            begin
                                if (run_reg)
                                begin
                                    // A run on the ray row ends; it crosses if
                                    // it leaves on the other side.
                                    if (!y_on_row)
                                    begin
                                        run_next = 1'b0;
                                        if (vert_y != run_prev_reg)
                                        begin
                                            hit_next = !hit_reg;
                                        end
                                    end
                                end
                                else if (y_on_row && x_side)
                                begin
                                    run_next = 1'b1;
                                    run_prev_next = prev_y_reg;
                                end
                            end
                            SCAN_PROX:
                            begin
                                if (in_reach)
                                begin
                                    hit_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                hit_next = hit_reg;
                            end
                        endcase
                    end
                end
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            issue_reg <= '0;
            dvalid_reg <= 1'b0;
            didx_reg <= '0;
            run_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            dvalid_reg <= dvalid_next;
            didx_reg <= didx_next;
            run_reg <= run_next;
            hit_reg <= hit_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        run_prev_reg <= run_prev_next;
        prev_y_reg <= prev_y_next;
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = done;
    assign stat.hit = hit_reg;

    // A pass is started only on an idle unit.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (state_reg == S_IDLE))
        else $error("scan started while busy");

    // Returned read data always belongs to a stored vertex.
    a_didx_range: assert property (@(posedge clk) disable iff (!rst_n)
        dvalid_reg |-> (didx_reg < cmd.count))
        else $error("scan read past vertex count");

    // The unit is idle right after finishing a pass.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> !stat.busy)
        else $error("scan busy after done");

endmodule

/* design/contour_point_inside_and_near_test_unit.sv */
// Inside and near test for one stored contour. A query runs a setup check,
// then up to three scan passes over the n stored vertices, the one vertex RAM
// read port feeding the scan unit a vertex per cycle.
// One request is in work at a time. Reset clears the count, box, flag and
// min_length; the vertex RAM is not cleared.
module contour_point_inside_and_near_test_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [cpin_pkg::MIN_LEN_W-1:0]     cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         action,
    input  logic                               first,
    input  logic signed [cpin_pkg::COORD_W-1:0] vertex_x,
    input  logic signed [cpin_pkg::COORD_W-1:0] vertex_y,
    input  logic [cpin_pkg::QUERY_W-1:0]       query_x,
    input  logic [cpin_pkg::QUERY_W-1:0]       query_y,
    input  logic [cpin_pkg::DIST_W-1:0]        near_distance,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               inside_res,
    output logic                               near,
    output logic                               overflow
);
    import cpin_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE,
        T_CHECK,
        T_RIGHT,
        T_LEFT,
        T_PROX,
        T_DONE
    } top_state_t;

    top_state_t                 state_reg, state_next;
    logic [MIN_LEN_W-1:0]       min_len_reg, min_len_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [COORD_W-1:0]  bmin_x_reg, bmin_x_next, bmax_x_reg, bmax_x_next;
    logic signed [COORD_W-1:0]  bmin_y_reg, bmin_y_next, bmax_y_reg, bmax_y_next;
    logic                       dropped_reg, dropped_next;
    logic [SCOORD_W-1:0]        sx_reg, sx_next, sy_reg, sy_next;
    logic [SDIST_W-1:0]         qdist_reg, qdist_next, sdist_reg, sdist_next;
    logic                       is_near_reg, is_near_next;
    logic                       ovf_reg, ovf_next;
    logic                       res_reg, res_next;
    logic                       start_reg, start_next;
    scan_mode_t                 mode_reg, mode_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       inside_res_reg, inside_res_next;
    logic                       near_reg, near_next;
    logic                       overflow_reg, overflow_next;

    logic                       accept, load_accept, full, ram_we;
    logic [CNT_W-1:0]           count_base;
    logic signed [COORD_W-1:0]  bmin_x_base, bmax_x_base, bmin_y_base, bmax_y_base;
    logic [SDIST_W-1:0]         box_pad;
    logic signed [CALC_W-1:0]   lo_x, hi_x, lo_y, hi_y;
    logic                       too_short, out_of_box;

    scan_cmd_t                  scan_cmd;
    scan_stat_t                 scan_stat;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [VERT_W-1:0]          rd_data;

    // Load path: clear on a first vertex, then store unless full.
    always_comb
    begin
        accept = in_valid && !in_stall;
        load_accept = accept && (action == ACT_LOAD);
        count_base = first ? '0 : count_reg;
        bmin_x_base = first ? COORD_MAX : bmin_x_reg;
        bmax_x_base = first ? COORD_MIN : bmax_x_reg;
        bmin_y_base = first ? COORD_MAX : bmin_y_reg;
        bmax_y_base = first ? COORD_MIN : bmax_y_reg;
        full = (count_base == CNT_W'(MAX_VERTICES));
        ram_we = load_accept && !full;
    end

    // Early rejection: short contour or point outside the (padded) box.
    always_comb
    begin
        box_pad = is_near_reg ? qdist_reg : '0;
        lo_x = $signed(CALC_W'(sx_reg)) - $signed(CALC_W'(box_pad));
        hi_x = $signed(CALC_W'(sx_reg)) + $signed(CALC_W'(box_pad));
        lo_y = $signed(CALC_W'(sy_reg)) - $signed(CALC_W'(box_pad));
        hi_y = $signed(CALC_W'(sy_reg)) + $signed(CALC_W'(box_pad));
        too_short = LEN_W'(count_reg) < LEN_W'(min_len_reg);
        out_of_box = (CALC_W'(bmin_x_reg) > hi_x) || (CALC_W'(bmax_x_reg) < lo_x) ||
                     (CALC_W'(bmin_y_reg) > hi_y) || (CALC_W'(bmax_y_reg) < lo_y);
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        min_len_next = cfg_wr_en ? cfg_wr_data : min_len_reg;
        count_next = count_reg;
        bmin_x_next = bmin_x_reg;
        bmax_x_next = bmax_x_reg;
        bmin_y_next = bmin_y_reg;
        bmax_y_next = bmax_y_reg;
        dropped_next = dropped_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        qdist_next = qdist_reg;
        sdist_next = sdist_reg;
        is_near_next = is_near_reg;
        ovf_next = ovf_reg;
        res_next = res_reg;
        start_next = 1'b0;
        mode_next = mode_reg;
        out_valid_next = out_valid_reg;
        inside_res_next = inside_res_reg;
        near_next = near_reg;
        overflow_next = overflow_reg;

        // The held result leaves when the receiver takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (load_accept)
                begin
                    count_next = count_base;
                    bmin_x_next = bmin_x_base;
                    bmax_x_next = bmax_x_base;
                    bmin_y_next = bmin_y_base;
                    bmax_y_next = bmax_y_base;
                    dropped_next = first ? 1'b0 : dropped_reg;
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = CNT_W'(count_base + 1'b1);
                        if (vertex_x < bmin_x_base)
                        begin
                            bmin_x_next = vertex_x;
                        end
                        if (vertex_x > bmax_x_base)
                        begin
                            bmax_x_next = vertex_x;
                        end
                        if (vertex_y < bmin_y_base)
                        begin
                            bmin_y_next = vertex_y;
                        end
                        if (vertex_y > bmax_y_base)
                        begin
                            bmax_y_next = vertex_y;
                        end
                    end
                end
                else if (accept && ((action == ACT_INSIDE) || (action == ACT_NEAR)))
                begin
                    sx_next = {query_x, 1'b0};
                    sy_next = {query_y, 1'b0};
                    qdist_next = {near_distance, 1'b0};
                    is_near_next = (action == ACT_NEAR);
                    ovf_next = dropped_reg;
                    state_next = T_CHECK;
                end
            end
            T_CHECK:
            begin
                if (too_short || out_of_box)
                begin
                    res_next = 1'b0;
                    state_next = T_DONE;
                end
                else if (is_near_reg)
                begin
                    start_next = 1'b1;
                    mode_next = SCAN_PROX;
                    sdist_next = qdist_reg;
                    state_next = T_PROX;
                end
                else
                begin
                    start_next = 1'b1;
                    mode_next = SCAN_RIGHT;
                    sdist_next = NEAR_LIMIT;
                    state_next = T_RIGHT;
                end
            end
            T_RIGHT:
            begin
                if (scan_stat.done)
                begin
                    if (scan_stat.hit)
                    begin
                        start_next = 1'b1;
                        mode_next = SCAN_LEFT;
                        state_next = T_LEFT;
                    end
                    else
                    begin
                        res_next = 1'b0;
                        state_next = T_DONE;
                    end
                end
            end
            T_LEFT:
            begin
                if (scan_stat.done)
                begin
                    if (scan_stat.hit)
                    begin
                        start_next = 1'b1;
                        mode_next = SCAN_PROX;
                        state_next = T_PROX;
                    end
                    else
                    begin
                        res_next = 1'b0;
                        state_next = T_DONE;
                    end
                end
            end
            T_PROX:
            begin
                if (scan_stat.done)
                begin
                    res_next = is_near_reg ? scan_stat.hit : !scan_stat.hit;
                    state_next = T_DONE;
                end
            end
            T_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    inside_res_next = !is_near_reg && res_reg;
                    near_next = is_near_reg && res_reg;
                    overflow_next = ovf_reg;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // State, contour registers and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            min_len_reg <= '0;
            count_reg <= '0;
            bmin_x_reg <= COORD_MAX;
            bmax_x_reg <= COORD_MIN;
            bmin_y_reg <= COORD_MAX;
            bmax_y_reg <= COORD_MIN;
            dropped_reg <= 1'b0;
            start_reg <= 1'b0;
            mode_reg <= SCAN_RIGHT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            min_len_reg <= min_len_next;
            count_reg <= count_next;
            bmin_x_reg <= bmin_x_next;
            bmax_x_reg <= bmax_x_next;
            bmin_y_reg <= bmin_y_next;
            bmax_y_reg <= bmax_y_next;
            dropped_reg <= dropped_next;
            start_reg <= start_next;
            mode_reg <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request payload and result payload registers.
    always_ff @(posedge clk)
    begin
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        qdist_reg <= qdist_next;
        sdist_reg <= sdist_next;
        is_near_reg <= is_near_next;
        ovf_reg <= ovf_next;
        res_reg <= res_next;
        inside_res_reg <= inside_res_next;
        near_reg <= near_next;
        overflow_reg <= overflow_next;
    end

    // Scan command.
    always_comb
    begin
        scan_cmd.start = start_reg;
        scan_cmd.mode = mode_reg;
        scan_cmd.sx = sx_reg;
        scan_cmd.sy = sy_reg;
        scan_cmd.radius = sdist_reg;
        scan_cmd.count = count_reg;
    end

    cpin_ram #(
        .WIDTH(VERT_W),
        .DEPTH(MAX_VERTICES)
    ) u_vertex_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(count_base[ADDR_W-1:0]),
        .wdata({vertex_x, vertex_y}),
        .re(rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    cpin_scan u_scan (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(scan_cmd),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .stat(scan_stat)
    );

    assign in_stall = (state_reg != T_IDLE);
    assign out_valid = out_valid_reg;
    assign inside_res = inside_res_reg;
    assign near = near_reg;
    assign overflow = overflow_reg;

    // The vertex count never passes the store depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    // A query result carries at most one of the two answers.
    a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(inside_res && near))
        else $error("both answers set");

    // A new result appears only from the finishing state.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == T_DONE))
        else $error("result without finished query");

    // The scan unit works only while a query is in progress.
    a_scan_owner: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stat.busy |-> ((state_reg == T_RIGHT) || (state_reg == T_LEFT) ||
                            (state_reg == T_PROX)))
        else $error("scan busy outside a query");

endmodule

/* dv/tb.sv */
// Testbench for contour_point_inside_and_near_test_unit: loads contours, asks inside and
// near questions and checks every answer against a behavioral predictor kept in this file.
// Depends on cpin_pkg and the unit itself; needs no files or arguments.
module tb;

    import cpin_pkg::*;

    localparam int PERIOD = 20;
    localparam int RANDOM_ITEMS = 290;
    localparam int PHASES = 5;
    localparam int LIMIT_CYCLES = 800000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 3 * MAX_VERTICES + 16;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // One answer as the unit reports it.
    typedef struct packed {
        logic inside_res;
        logic near;
        logic overflow;
    } query_answer_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [MIN_LEN_W-1:0]        cfg_wr_data;
    logic                        in_valid;
    logic                        in_stall;
    logic [1:0]                  action;
    logic                        first;
    logic signed [COORD_W-1:0]   vertex_x;
    logic signed [COORD_W-1:0]   vertex_y;
    logic [QUERY_W-1:0]          query_x;
    logic [QUERY_W-1:0]          query_y;
    logic [DIST_W-1:0]           near_distance;
    logic                        out_valid;
    logic                        out_stall;
    logic                        inside_res;
    logic                        near;
    logic                        overflow;

    // Predictor copy of the contour, its box and the register.
    int trace_x [MAX_VERTICES];
    int trace_y [MAX_VERTICES];
    int trace_len;
    int box_lo_x;
    int box_hi_x;
    int box_lo_y;
    int box_hi_y;
    bit lost_vertices;
    int min_len_cfg;

    query_answer_t pending_answers [$];
    query_answer_t want;

    int errors = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int answers_checked = 0;
    int traces_loaded = 0;
    int cfg_writes = 0;

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    bit rx_hold = 1'b0;
    int hold_len = 0;
    int rx_burst = 0;

    contour_point_inside_and_near_test_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .first         (first),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .query_x       (query_x),
        .query_y       (query_y),
        .near_distance (near_distance),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .inside_res    (inside_res),
        .near          (near),
        .overflow      (overflow)
    );

    // Clock and cycle counter.
    initial
    begin
        clk = 1'b0;
    end

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // A hung unit ends the run here.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Forget the contour: empty box, no vertices, no drop flag.
    function automatic void clear_trace_model();
        trace_len = 0;
        box_lo_x = int'(COORD_MAX);
        box_lo_y = int'(COORD_MAX);
        box_hi_x = int'(COORD_MIN);
        box_hi_y = int'(COORD_MIN);
        lost_vertices = 1'b0;
    endfunction

    function automatic int abs_gap(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Horizontal ray crossings over the inner vertices; a run on the row counts once.
    function automatic int ray_hits(int sx, int sy, bit to_right);
        int hits;
        int p;
        int row;
        int prev_row;
        bit side;
        hits = 0;
        if (trace_len < 3)
            return 0;
        p = 1;
        while (p < trace_len - 1)
        begin
            side = to_right ? (trace_x[p] > sx) : (trace_x[p] < sx);
            if (trace_y[p] == sy && side)
            begin
                row = trace_y[p];
                prev_row = trace_y[p - 1];
                p++;
                while (p < trace_len - 1 && trace_y[p] == row)
                    p++;
                if (p < trace_len - 1 && trace_y[p] != prev_row)
                    hits++;
            end
            p++;
        end
        return hits;
    endfunction

    // True when an inner vertex is within d of the point on both axes.
    function automatic bit vertex_close(int sx, int sy, int d);
        if (trace_len < 3)
            return 1'b0;
        for (int p = 1; p < trace_len - 1; p++)
        begin
            if (abs_gap(trace_x[p], sx) <= d && abs_gap(trace_y[p], sy) <= d)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit inside_answer(int sx, int sy);
        if (trace_len < min_len_cfg)
            return 1'b0;
        if (box_lo_x > sx || box_hi_x < sx || box_lo_y > sy || box_hi_y < sy)
            return 1'b0;
        if (ray_hits(sx, sy, 1'b1) % 2 == 0)
            return 1'b0;
        if (ray_hits(sx, sy, 1'b0) % 2 == 0)
            return 1'b0;
        return !vertex_close(sx, sy, int'(NEAR_LIMIT));
    endfunction

    function automatic bit near_answer(int sx, int sy, int d);
        if (trace_len < min_len_cfg)
            return 1'b0;
        if (box_lo_x > sx + d || box_hi_x < sx - d || box_lo_y > sy + d || box_hi_y < sy - d)
            return 1'b0;
        return vertex_close(sx, sy, d);
    endfunction

    // Apply one accepted request to the predictor and queue its answer, if any.
    function automatic void predict_request(logic [1:0] act, logic clr,
                                            logic signed [COORD_W-1:0] px,
                                            logic signed [COORD_W-1:0] py,
                                            logic [QUERY_W-1:0] qx, logic [QUERY_W-1:0] qy,
                                            logic [DIST_W-1:0] tol);
        int sx;
        int sy;
        int d;
        query_answer_t ans;
        sx = int'(qx) * 2;
        sy = int'(qy) * 2;
        d = int'(tol) * 2;
        ans = '0;
        case (act)
            ACT_LOAD:
            begin
                if (clr)
                    clear_trace_model();
                if (trace_len >= MAX_VERTICES)
                    lost_vertices = 1'b1;
                else
                begin
                    trace_x[trace_len] = int'(px);
                    trace_y[trace_len] = int'(py);
                    trace_len++;
                    if (int'(px) < box_lo_x) box_lo_x = int'(px);
                    if (int'(px) > box_hi_x) box_hi_x = int'(px);
                    if (int'(py) < box_lo_y) box_lo_y = int'(py);
                    if (int'(py) > box_hi_y) box_hi_y = int'(py);
                end
            end
            ACT_INSIDE:
            begin
                ans.inside_res = inside_answer(sx, sy);
                ans.overflow = lost_vertices;
                pending_answers = {pending_answers, ans};
            end
            ACT_NEAR:
            begin
                ans.near = near_answer(sx, sy, d);
                ans.overflow = lost_vertices;
                pending_answers = {pending_answers, ans};
            end
            default:
            begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Result side: stall generation and answer checking
    // ---------------------------------------------------------------

    // Long hold-off, counted here in cycles once a test asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                rx_hold = 1'b1;
                repeat (hold_len) @(posedge clk);
                rx_hold = 1'b0;
                hold_len = 0;
            end
        end
    end

    // Random stall bursts, plus the long hold-off.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_burst > 0)
                rx_burst--;
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
                rx_burst = $urandom_range(1, 16);
            out_stall = rx_hold || (rx_burst > 0);
        end
    end

    // Compare each accepted answer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("answer with none pending: inside_res %0b near %0b overflow %0b",
                       inside_res, near, overflow);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (inside_res !== want.inside_res)
                begin
                    $error("inside_res: expected %0b, got %0b", want.inside_res, inside_res);
                    errors++;
                end
                if (near !== want.near)
                begin
                    $error("near: expected %0b, got %0b", want.near, near);
                    errors++;
                end
                if (overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", want.overflow, overflow);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------

    // Offer one request at the falling edge and hold it until accepted.
    task automatic send_request(input logic [1:0] act, input logic clr,
                                input logic signed [COORD_W-1:0] px,
                                input logic signed [COORD_W-1:0] py,
                                input logic [QUERY_W-1:0] qx, input logic [QUERY_W-1:0] qy,
                                input logic [DIST_W-1:0] tol);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        action = act;
        first = clr;
        vertex_x = px;
        vertex_y = py;
        query_x = qx;
        query_y = qy;
        near_distance = tol;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(act, clr, px, py, qx, qy, tol);
        if (act != ACT_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // Load request; the query fields carry random don't-care values.
    task automatic load_vertex(input bit clr, input int x, input int y);
        send_request(ACT_LOAD, clr, 16'(x), 16'(y), 14'($urandom), 14'($urandom),
                     13'($urandom));
    endtask

    // Query request; the load fields carry random don't-care values.
    task automatic ask(input logic [1:0] act, input int qx, input int qy, input int tol);
        send_request(act, 1'($urandom), 16'($urandom), 16'($urandom), 14'(qx), 14'(qy),
                     13'(tol));
    endtask

    // Drop valid, wait for every answer, then let a trailing load finish.
    task automatic settle();
        in_valid = 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_min_length(input int value);
        settle();
        cfg_wr_data = MIN_LEN_W'(value);
        cfg_wr_en = 1'b1;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        min_len_cfg = value;
        cfg_writes++;
    endtask

    function automatic int wobble();
        return 2 * int'($urandom_range(0, 4)) - 4;
    endfunction

    // Closed outline on even coordinates: a horizontal run along the top and the
    // bottom, one vertex per row down each side, ending back on the start vertex.
    task automatic load_trace(input int x0, input int y0, input int w, input int rows);
        int x1;
        int yb;
        x1 = x0 + w;
        yb = y0 + 2 * rows;
        load_vertex(1'b1, x0, y0);
        for (int k = 1; k < 4; k++)
            load_vertex(1'b0, x0 + w * k / 8 * 2, y0);
        for (int r = 1; r <= rows; r++)
            load_vertex(1'b0, x1 + wobble(), y0 + 2 * r);
        for (int k = 3; k > 0; k--)
            load_vertex(1'b0, x0 + w * k / 8 * 2, yb);
        for (int r = rows; r > 0; r--)
            load_vertex(1'b0, x0 + wobble(), y0 + 2 * r);
        load_vertex(1'b0, x0, y0);
        traces_loaded++;
    endtask

    // Queries around an outline: points in the box, near it and just outside.
    task automatic probe_trace(input int x0, input int y0, input int w, input int rows,
                               input int count);
        int qx;
        int qy;
        repeat (count)
        begin
            qx = (x0 + int'($urandom_range(0, w))) / 2;
            qy = y0 / 2 + int'($urandom_range(0, rows));
            case ($urandom_range(0, 5))
                0, 1, 2:
                    ask(ACT_INSIDE, qx, qy, $urandom_range(0, 8191));
                3:
                    ask(ACT_NEAR, qx, qy, $urandom_range(0, 6));
                4:
                    ask(ACT_NEAR, qx + int'($urandom_range(0, 16)) - 8,
                        qy + int'($urandom_range(0, 16)) - 8, $urandom_range(0, 40));
                default:
                begin
                    if ($urandom_range(0, 1) == 1)
                        ask(ACT_INSIDE, qx, y0 / 2 - int'($urandom_range(1, 3)), 0);
                    else
                        ask(ACT_INSIDE, (x0 + w) / 2 + int'($urandom_range(3, 10)), qy, 0);
                end
            endcase
        end
    endtask

    // Well-formed outline with random placement, sometimes broken by stray loads.
    task automatic random_trace();
        int w;
        int rows;
        int x0;
        int y0;
        w = 2 * int'($urandom_range(10, 100));
        rows = $urandom_range(1, 12);
        x0 = 2 * int'($urandom_range(20, 16000));
        y0 = 2 * int'($urandom_range(20, 16300));
        load_trace(x0, y0, w, rows);
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 3))
                load_vertex(1'b0, x0 + 2 * int'($urandom_range(0, w / 2)),
                            y0 + 2 * int'($urandom_range(0, rows)));
        end
        probe_trace(x0, y0, w, rows, $urandom_range(2, 6));
    endtask

    // Noise: arbitrary loads and queries over the full field ranges.
    task automatic random_noise();
        int cx;
        int cy;
        case ($urandom_range(0, 4))
            0:
            begin
                repeat ($urandom_range(1, 6))
                    load_vertex(1'($urandom), int'($urandom_range(0, 65535)) - 32768,
                                int'($urandom_range(0, 65535)) - 32768);
            end
            1:
                ask(ACT_INSIDE, $urandom_range(0, 16383), $urandom_range(0, 16383),
                    $urandom_range(0, 8191));
            2:
                ask(ACT_NEAR, $urandom_range(0, 16383), $urandom_range(0, 16383),
                    $urandom_range(0, 8191));
            3:
                send_request(ACT_UNUSED, 1'($urandom), 16'($urandom), 16'($urandom),
                             14'($urandom), 14'($urandom), 13'($urandom));
            default:
            begin
                // A contour too short to have more than one inner vertex.
                cx = 2 * int'($urandom_range(0, 16383));
                cy = 2 * int'($urandom_range(0, 16383));
                load_vertex(1'b1, cx, cy);
                repeat ($urandom_range(0, 2))
                    load_vertex(1'b0, cx + int'($urandom_range(0, 8)) - 4,
                                cy + int'($urandom_range(0, 8)) - 4);
                ask(ACT_NEAR, cx / 2, cy / 2, $urandom_range(0, 4));
                ask(ACT_INSIDE, cx / 2, cy / 2, 0);
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Queries before any load see an empty box; the unused code does nothing.
    task automatic test_empty_after_reset();
        ask(ACT_INSIDE, 0, 0, 0);
        ask(ACT_NEAR, 16383, 16383, 8191);
        ask(ACT_NEAR, 0, 0, 8191);
        send_request(ACT_UNUSED, 1'b1, 16'sh7FFF, 16'sh8000, 14'h3FFF, 14'h3FFF, 13'h1FFF);
    endtask

    // Coordinate and distance extremes on contours of one, two and three vertices.
    task automatic test_field_extremes();
        load_vertex(1'b1, -32768, -32768);
        ask(ACT_NEAR, 0, 0, 8191);
        load_vertex(1'b0, 32767, 32767);
        ask(ACT_NEAR, 16383, 16383, 8191);
        load_vertex(1'b0, 100, 100);
        ask(ACT_NEAR, 16383, 16383, 0);
        ask(ACT_NEAR, 16383, 16383, 1);
        ask(ACT_INSIDE, 16383, 16383, 8191);
        ask(ACT_NEAR, 0, 0, 8191);
    endtask

    // A small outline with in-box, on-row-run and outside queries.
    task automatic test_trace_shape();
        load_trace(100, 100, 20, 2);
        ask(ACT_INSIDE, 55, 51, 0);
        ask(ACT_INSIDE, 55, 50, 0);
        ask(ACT_INSIDE, 55, 52, 0);
        ask(ACT_NEAR, 52, 50, 0);
        ask(ACT_NEAR, 70, 51, 2);
        ask(ACT_INSIDE, 80, 51, 0);
    endtask

    // Length threshold at the store depth, at zero and right at the stored count.
    task automatic test_min_length_gate();
        write_min_length(1024);
        ask(ACT_INSIDE, 55, 52, 0);
        ask(ACT_NEAR, 52, 50, 2);
        write_min_length(trace_len);
        ask(ACT_NEAR, 52, 50, 2);
        write_min_length(trace_len + 1);
        ask(ACT_NEAR, 52, 50, 2);
        write_min_length(0);
    endtask

    // Fill the store exactly, then overrun it; a clearing load drops the flag.
    task automatic test_store_full();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        load_vertex(1'b1, 400, 400);
        repeat (MAX_VERTICES - 1)
            load_vertex(1'b0, 2 * int'($urandom_range(100, 300)),
                        2 * int'($urandom_range(100, 300)));
        ask(ACT_NEAR, 200, 200, 10);
        repeat (2)
            load_vertex(1'b0, 200, 200);
        ask(ACT_INSIDE, 200, 200, 0);
        ask(ACT_NEAR, 0, 0, 8191);
        load_vertex(1'b1, 200, 200);
        ask(ACT_NEAR, 100, 100, 0);
        settle();
    endtask

    // The result side holds off while requests keep coming, so the unit backs up.
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        load_trace(600, 800, 60, 4);
        hold_len = HOLD_CYCLES;
        repeat (6)
            probe_trace(600, 800, 60, 4, 1);
        settle();
    endtask

    // Random phases, each with its own threshold and idling; the last has no idling.
    task automatic test_random_traces();
        int stop_at;
        int lens [PHASES];
        bit tx_on [PHASES];
        bit rx_on [PHASES];
        lens = '{0, int'($urandom_range(3, 30)), 2, int'($urandom_range(1, 12)), 0};
        tx_on = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        rx_on = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_min_length(lens[ph]);
            tx_idle_on = tx_on[ph];
            rx_idle_on = rx_on[ph];
            stop_at = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < stop_at)
            begin
                if ($urandom_range(0, 3) != 0)
                    random_trace();
                else
                    random_noise();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        action = ACT_LOAD;
        first = 1'b0;
        vertex_x = '0;
        vertex_y = '0;
        query_x = '0;
        query_y = '0;
        near_distance = '0;
        clear_trace_model();
        min_len_cfg = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_empty_after_reset();
        test_field_extremes();
        test_trace_shape();
        test_min_length_gate();
        test_store_full();
        test_output_backpressure();
        test_random_traces();

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("tb: %0d requests sent, %0d answers checked, %0d outlines traced",
                 items_sent, answers_checked, traces_loaded);
        $display("tb: min_length written %0d times, store overrun once", cfg_writes);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* contour_point_inside_and_near_test_unit.f */
design/cpin_pkg.sv
design/cpin_ram.sv
design/cpin_scan.sv
design/contour_point_inside_and_near_test_unit.sv
dv/tb.sv
